### design/salcl_pkg.sv
// Shared types and constants for the set-associative LRU cache lookup block.
`timescale 1ns / 1ps
package salcl_pkg;

  localparam int MaxSets = 512;
  localparam int MaxWays = 8;
  localparam int BlockBytes = 64;
  localparam int AddrBits = 32;

  localparam int SetBits = $clog2(MaxSets);
  localparam int WayBits = $clog2(MaxWays);
  localparam int OffBits = $clog2(BlockBytes);
  localparam int BlkBits = AddrBits - OffBits;
  localparam int TagBits = BlkBits;
  localparam int AgeBits = 3;
  localparam int CfgBits = 4;
  localparam int SibMax = 12;
  localparam int CntBits = 32;
  localparam int MetaBits = MaxWays + MaxWays * AgeBits;
  localparam int TagRowBits = MaxWays * TagBits;
  localparam int OutBits = 72;
  localparam int QueueDepth = 2;

  localparam logic [AgeBits-1:0] AgeMax = '1;

  localparam logic CfgWays = 1'b0;
  localparam logic CfgSetBits = 1'b1;

  typedef struct packed {
    logic clr;
    logic [SetBits-1:0] set_idx;
    logic [TagBits-1:0] tag;
  } req_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC
  } back_state_t;

endpackage

### design/salcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module salcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/salcl_front.sv
// Front end: accepts requests, splits the address into set and tag, and queues them.
`timescale 1ns / 1ps
module salcl_front import salcl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [AddrBits-1:0] s_tdata,
  input  logic               s_tuser,
  input  logic [CfgBits-1:0] set_index_bits,
  input  logic               init_busy,
  output logic               q_valid,
  output req_t               q_req,
  input  logic               q_pop
);

  req_t q_mem [QueueDepth];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic [CfgBits-1:0] sib;
  logic [BlkBits-1:0] blk;
  logic [SetBits-1:0] set_mask;
  req_t new_req;

  always_comb begin
    sib = (set_index_bits > CfgBits'(SibMax)) ? CfgBits'(SibMax) : set_index_bits;
    blk = s_tdata[AddrBits-1:OffBits];
    set_mask = ~({SetBits{1'b1}} << sib);
    new_req.clr = s_tuser;
    new_req.set_idx = blk[SetBits-1:0] & set_mask;
    new_req.tag = blk >> sib;
  end

  assign s_tready = (count != 2'(QueueDepth)) && !init_busy;
  assign push = s_tvalid && s_tready;
  assign q_valid = (count != 2'd0);
  assign q_req = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

### design/salcl_back.sv
// Back end: reads a set, resolves hit or victim, updates LRU ages and counters.
`timescale 1ns / 1ps
module salcl_back import salcl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  req_t               q_req,
  output logic               q_pop,
  input  logic [CfgBits-1:0] ways_in_use,
  output logic               init_busy,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OutBits-1:0] m_tdata
);

  back_state_t state;
  back_state_t state_next;
  logic [SetBits-1:0] sweep_idx;
  req_t cur;
  logic out_valid;
  logic out_hit;
  logic [WayBits-1:0] out_way;
  logic [CntBits-1:0] hit_cnt;
  logic [CntBits-1:0] acc_cnt;

  logic slot_free;
  logic [SetBits-1:0] rd_addr;
  logic meta_we;
  logic [SetBits-1:0] wr_addr;
  logic [MetaBits-1:0] meta_wdata;
  logic [MetaBits-1:0] meta_rdata;
  logic tag_we;
  logic [TagRowBits-1:0] tag_wdata;
  logic [TagRowBits-1:0] tag_rdata;

  logic [CfgBits-1:0] nways;
  logic [MaxWays-1:0] valid;
  logic [AgeBits-1:0] age [MaxWays];
  logic hit;
  logic [WayBits-1:0] hit_way;
  logic inv_found;
  logic [WayBits-1:0] inv_way;
  logic [AgeBits-1:0] best_age;
  logic [WayBits-1:0] old_way;
  logic [WayBits-1:0] used;
  logic [AgeBits:0] ref_age;
  logic [MetaBits-1:0] new_meta;
  logic [TagRowBits-1:0] new_tags;

  salcl_ram #(.WIDTH(MetaBits), .DEPTH(MaxSets)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(wr_addr), .wdata(meta_wdata),
    .raddr(rd_addr), .rdata(meta_rdata)
  );

  salcl_ram #(.WIDTH(TagRowBits), .DEPTH(MaxSets)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(wr_addr), .wdata(tag_wdata),
    .raddr(rd_addr), .rdata(tag_rdata)
  );

  assign slot_free = !out_valid || m_tready;

  always_comb begin
    nways = ways_in_use;
    if (ways_in_use == '0) begin
      nways = CfgBits'(1);
    end else if (ways_in_use > CfgBits'(MaxWays)) begin
      nways = CfgBits'(MaxWays);
    end
    valid = meta_rdata[MaxWays-1:0];
    for (int w = 0; w < MaxWays; w++) begin
      age[w] = meta_rdata[MaxWays + w*AgeBits +: AgeBits];
    end
    hit = 1'b0;
    hit_way = '0;
    inv_found = 1'b0;
    inv_way = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if ((CfgBits'(w) < nways) && valid[w]
          && (tag_rdata[w*TagBits +: TagBits] == cur.tag)) begin
        hit = 1'b1;
        hit_way = WayBits'(w);
      end
      if ((CfgBits'(w) < nways) && !valid[w]) begin
        inv_found = 1'b1;
        inv_way = WayBits'(w);
      end
    end
    best_age = age[0];
    old_way = '0;
    for (int w = 1; w < MaxWays; w++) begin
      if ((CfgBits'(w) < nways) && (age[w] > best_age)) begin
        best_age = age[w];
        old_way = WayBits'(w);
      end
    end
    used = hit ? hit_way : (inv_found ? inv_way : old_way);
    ref_age = hit ? {1'b0, age[used]} : {1'b1, {AgeBits{1'b0}}};
    new_meta = meta_rdata;
    new_meta[used] = 1'b1;
    for (int w = 0; w < MaxWays; w++) begin
      if (WayBits'(w) == used) begin
        new_meta[MaxWays + w*AgeBits +: AgeBits] = '0;
      end else if ((CfgBits'(w) < nways) && valid[w]
                   && ({1'b0, age[w]} < ref_age) && (age[w] != AgeMax)) begin
        new_meta[MaxWays + w*AgeBits +: AgeBits] = age[w] + AgeBits'(1);
      end
    end
    new_tags = tag_rdata;
    new_tags[used*TagBits +: TagBits] = cur.tag;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (sweep_idx == SetBits'(MaxSets - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && slot_free && !q_req.clr) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    meta_we = 1'b0;
    tag_we = 1'b0;
    wr_addr = cur.set_idx;
    meta_wdata = new_meta;
    tag_wdata = new_tags;
    rd_addr = q_req.set_idx;
    init_busy = 1'b0;
    unique case (state)
      ST_INIT: begin
        init_busy = 1'b1;
        meta_we = 1'b1;
        wr_addr = sweep_idx;
        meta_wdata = '0;
      end
      ST_IDLE: q_pop = q_valid && slot_free;
      ST_EXEC: begin
        meta_we = 1'b1;
        tag_we = !hit;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      sweep_idx <= '0;
      out_valid <= 1'b0;
      out_hit <= 1'b0;
      out_way <= '0;
      hit_cnt <= '0;
      acc_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        sweep_idx <= sweep_idx + SetBits'(1);
      end
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      if (q_pop && q_req.clr) begin
        out_valid <= 1'b1;
        out_hit <= 1'b0;
        out_way <= '0;
        hit_cnt <= '0;
        acc_cnt <= '0;
      end else if (state == ST_EXEC) begin
        out_valid <= 1'b1;
        out_hit <= hit;
        out_way <= used;
        if (acc_cnt != '1) begin
          acc_cnt <= acc_cnt + CntBits'(1);
        end
        if (hit && (hit_cnt != '1)) begin
          hit_cnt <= hit_cnt + CntBits'(1);
        end
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {{(OutBits - 1 - WayBits - 2*CntBits){1'b0}},
                    acc_cnt, hit_cnt, out_way, out_hit};

endmodule

### design/set_assoc_lru_cache_lookup_top.sv
// Results are registered: a lookup's after its set read and execute state, a clear's on its pop.
// A new lookup is not started until the read-then-write pass over the set memories ends.
// A two-entry request queue lets the front keep accepting while a result waits at the output.
// Reset is synchronous; afterwards a pass over all 512 sets clears valid bits and ages, one set per cycle,
// and no request is accepted until it finishes. Configuration writes are taken at any time.
`timescale 1ns / 1ps
module set_assoc_lru_cache_lookup_top import salcl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [AddrBits-1:0] s_tdata,  // address
  input  logic                s_tuser,  // cmd
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutBits-1:0]  m_tdata,  // hit, way_used, hit_count, access_count, zero pad
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CfgBits-1:0]  cfg_data
);

  logic [CfgBits-1:0] ways_in_use;
  logic [CfgBits-1:0] set_index_bits;
  logic init_busy;
  logic q_valid;
  logic q_pop;
  req_t q_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= CfgBits'(MaxWays);
      set_index_bits <= CfgBits'(SetBits);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgWays: ways_in_use <= cfg_data;
        CfgSetBits: set_index_bits <= cfg_data;
        default: ways_in_use <= ways_in_use;
      endcase
    end
  end

  salcl_front u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .set_index_bits(set_index_bits), .init_busy(init_busy),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  salcl_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .ways_in_use(ways_in_use), .init_busy(init_busy),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

endmodule
